// ----- rtl/rmq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // quaternion slot that takes the root component
    typedef enum logic [1:0] {
        SLOT_W = 2'd0,
        SLOT_X = 2'd1,
        SLOT_Y = 2'd2,
        SLOT_Z = 2'd3
    } t_slot;

    localparam int LANES     = 3;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

endpackage
`default_nettype wire

// ----- rtl/rmq_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rmq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rmq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front
// Classify a matrix: pick the root slot, form the radicand and the three
// numerators as sign and magnitude.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int W = 16,
    parameter int F = 14,
    parameter int SU = 18
) (
    input  wire logic signed [W-1:0] i_m00, i_m01, i_m02,
    input  wire logic signed [W-1:0] i_m10, i_m11, i_m12,
    input  wire logic signed [W-1:0] i_m20, i_m21, i_m22,
    output rmq_pkg::t_slot           o_slot,
    output logic [SU-1:0]            o_rad,
    output logic [2:0]               o_neg,
    output logic [2:0][W:0]          o_mag
);
    import rmq_pkg::*;

    localparam int SS = SU + 1;

    logic signed [SS-1:0] e00, e11, e22, one, trace, rad_s;
    logic signed [W:0]    x01, x02, x10, x12, x20, x21;
    logic signed [W:0]    d [0:2];

    always_comb begin
        e00   = {{(SS-W){i_m00[W-1]}}, i_m00};
        e11   = {{(SS-W){i_m11[W-1]}}, i_m11};
        e22   = {{(SS-W){i_m22[W-1]}}, i_m22};
        one   = {{(SS-F-1){1'b0}}, 1'b1, {F{1'b0}}};
        trace = e00 + e11 + e22;
        x01   = {i_m01[W-1], i_m01};
        x02   = {i_m02[W-1], i_m02};
        x10   = {i_m10[W-1], i_m10};
        x12   = {i_m12[W-1], i_m12};
        x20   = {i_m20[W-1], i_m20};
        x21   = {i_m21[W-1], i_m21};

        priority if (trace > 0) begin
            o_slot = SLOT_W;
        end else if (e22 > ((e11 > e00) ? e11 : e00)) begin
            o_slot = SLOT_Z;
        end else if (e11 > e00) begin
            o_slot = SLOT_Y;
        end else begin
            o_slot = SLOT_X;
        end

        unique case (o_slot)
            SLOT_W: begin
                rad_s = trace + one;
                d[0]  = x21 - x12;
                d[1]  = x02 - x20;
                d[2]  = x10 - x01;
            end
            SLOT_X: begin
                rad_s = e00 - e11 - e22 + one;
                d[0]  = x21 - x12;
                d[1]  = x10 + x01;
                d[2]  = x20 + x02;
            end
            SLOT_Y: begin
                rad_s = e11 - e22 - e00 + one;
                d[0]  = x02 - x20;
                d[1]  = x01 + x10;
                d[2]  = x21 + x12;
            end
            SLOT_Z: begin
                rad_s = e22 - e00 - e11 + one;
                d[0]  = x10 - x01;
                d[1]  = x02 + x20;
                d[2]  = x12 + x21;
            end
            default: begin
                rad_s = '0;
                d[0]  = '0;
                d[1]  = '0;
                d[2]  = '0;
            end
        endcase

        o_rad = (rad_s > 0) ? rad_s[SU-1:0] : '0;
        for (int l = 0; l < 3; l++) begin
            o_neg[l] = d[l][W];
            o_mag[l] = d[l][W] ? (W+1)'(-d[l]) : (W+1)'(d[l]);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rmq_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root of rad << FRAC, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int IN_W   = 18,
    parameter int FRAC   = 14,
    parameter int RW     = 16,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [RW-1:0]          o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int NPW  = 2 * RW;
    localparam int REMW = RW + 2;

    logic              r_valid [0:RW];
    logic [NPW-1:0]    r_n     [0:RW];
    logic [REMW-1:0]   r_rem   [0:RW];
    logic [RW-1:0]     r_root  [0:RW];
    logic [SIDE_W-1:0] r_side  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= NPW'({i_rad, {FRAC{1'b0}}});
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic [REMW+1:0] t, trial, diff;
        logic            ge;

        always_comb begin
            t     = {r_rem[s], r_n[s][NPW-1 -: 2]};
            trial = (REMW+2)'({r_root[s], 2'b01});
            ge    = (t >= trial);
            diff  = t - trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]    <= {r_n[s][NPW-3:0], 2'b00};
                r_rem[s+1]  <= ge ? diff[REMW-1:0] : t[REMW-1:0];
                r_root[s+1] <= {r_root[s][RW-2:0], ge};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule
`default_nettype wire

// ----- rtl/rmq_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, three dividends over one shared divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int NUM_W  = 31,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic [rmq_pkg::LANES-1:0][NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]                     i_den,
    input  wire logic [SIDE_W-1:0]                    i_side,
    output logic                                      o_valid,
    output logic [rmq_pkg::LANES-1:0][NUM_W-1:0]      o_quo,
    output logic [SIDE_W-1:0]                         o_side
);
    import rmq_pkg::*;

    logic                         r_valid [0:NUM_W];
    logic [LANES-1:0][NUM_W-1:0]  r_num   [0:NUM_W];
    logic [LANES-1:0][DEN_W-1:0]  r_rem   [0:NUM_W];
    logic [DEN_W-1:0]             r_den   [0:NUM_W];
    logic [SIDE_W-1:0]            r_side  [0:NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0]  <= i_num;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][NUM_W-1:0] n_num;

        always_comb begin
            logic [DEN_W:0] t, diff;
            logic           ge;
            for (int l = 0; l < LANES; l++) begin
                t        = {r_rem[s][l], r_num[s][l][NUM_W-1]};
                ge       = (t >= {1'b0, r_den[s]});
                diff     = t - {1'b0, r_den[s]};
                n_rem[l] = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                n_num[l] = {r_num[s][l][NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1]  <= n_num;
                r_rem[s+1]  <= n_rem;
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_valid[NUM_W];
    assign o_quo   = r_num[NUM_W];
    assign o_side  = r_side[NUM_W];

endmodule
`default_nettype wire

// ----- rtl/rmq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_back
// Root, divide, saturate and place the quaternion components; results
// wait in a short output queue.
// ----------------------------------------------------------------------------
module rmq_back #(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int SU = 18
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_take,
    input  wire rmq_pkg::t_slot                    i_slot,
    input  wire logic [SU-1:0]                     i_rad,
    input  wire logic [2:0]                        i_neg,
    input  wire logic [2:0][W:0]                   i_mag,
    input  wire logic                              i_pop,
    output logic                                   o_empty,
    output logic signed [W-1:0]                    o_qw,
    output logic signed [W-1:0]                    o_qx,
    output logic signed [W-1:0]                    o_qy,
    output logic signed [W-1:0]                    o_qz
);
    import rmq_pkg::*;

    localparam int NW  = SU + F;
    localparam int RW  = (NW + 1) / 2;
    localparam int QW  = W + 1 + F;
    localparam int DW  = RW + 1;
    localparam int SB1 = 2 + 3 + 3 * (W + 1);
    localparam int SB2 = 2 + 3 + 3 + (RW - 1);
    localparam int CW  = (RW - 1 > W) ? (RW - 1) : W;

    logic                   en, out_full, sq_valid, dv_valid;
    logic [RW-1:0]          sq_root;
    logic [SB1-1:0]         sq_side;
    t_slot                  sq_slot;
    logic [2:0]             sq_neg, sq_zero;
    logic [2:0][W:0]        sq_mag;
    logic [LANES-1:0][QW-1:0] dv_num, dv_quo;
    logic [SB2-1:0]         dv_side;
    t_slot                  fin_slot;
    logic [2:0]             fin_neg, fin_zero;
    logic [RW-2:0]          fin_rh;
    logic [W-1:0]           comp [0:2];
    logic [W-1:0]           rootc;
    logic [4*W-1:0]         res;
    logic [4*W-1:0]         out_data;

    // stall the whole back end while the output queue is full
    assign en     = !out_full;
    assign o_take = en && i_valid;

    rmq_sqrt #(.IN_W(SU), .FRAC(F), .RW(RW), .SIDE_W(SB1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_rad   (i_rad),
        .i_side  ({i_slot, i_neg, i_mag}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        sq_slot = t_slot'(sq_side[SB1-1 -: 2]);
        sq_neg  = sq_side[3*(W+1) +: 3];
        sq_mag  = sq_side[3*(W+1)-1:0];
        for (int l = 0; l < LANES; l++) begin
            dv_num[l]  = {sq_mag[l], {F{1'b0}}};
            sq_zero[l] = (sq_mag[l] == '0);
        end
    end

    rmq_div #(.NUM_W(QW), .DEN_W(DW), .SIDE_W(SB2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   (dv_num),
        .i_den   ({sq_root, 1'b0}),
        .i_side  ({sq_slot, sq_neg, sq_zero, sq_root[RW-1:1]}),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_comb begin
        logic [QW-1:0] smax_q, negq;
        logic [CW-1:0] rh_ext, smax_c;
        logic [W-1:0]  smax, smin;
        fin_slot = t_slot'(dv_side[SB2-1 -: 2]);
        fin_neg  = dv_side[RW+2 +: 3];
        fin_zero = dv_side[RW-1 +: 3];
        fin_rh   = dv_side[RW-2:0];
        smax     = {1'b0, {(W-1){1'b1}}};
        smin     = {1'b1, {(W-1){1'b0}}};
        smax_q   = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
        for (int l = 0; l < LANES; l++) begin
            negq = ~dv_quo[l] + QW'(1);
            priority if (fin_zero[l]) begin
                comp[l] = '0;
            end else if (fin_neg[l]) begin
                comp[l] = (dv_quo[l] > smax_q + QW'(1)) ? smin : negq[W-1:0];
            end else begin
                comp[l] = (dv_quo[l] > smax_q) ? smax : dv_quo[l][W-1:0];
            end
        end
        rh_ext = CW'(fin_rh);
        smax_c = CW'(smax);
        rootc  = (rh_ext > smax_c) ? smax : rh_ext[W-1:0];
        unique case (fin_slot)
            SLOT_W:  res = {rootc, comp[0], comp[1], comp[2]};
            SLOT_X:  res = {comp[0], rootc, comp[1], comp[2]};
            SLOT_Y:  res = {comp[0], comp[1], rootc, comp[2]};
            SLOT_Z:  res = {comp[0], comp[1], comp[2], rootc};
            default: res = '0;
        endcase
    end

    rmq_fifo #(.WIDTH(4*W), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dv_valid && en),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_data),
        .o_empty (o_empty)
    );

    assign o_qw = out_data[4*W-1 -: W];
    assign o_qx = out_data[3*W-1 -: W];
    assign o_qy = out_data[2*W-1 -: W];
    assign o_qz = out_data[W-1:0];

endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// A matrix passes RW root stages, then QW divider stages, where
//   RW = ceil((max(DATA_WIDTH, FRAC_BITS) + 2 + FRAC_BITS) / 2) root stages and
//   QW = DATA_WIDTH + 1 + FRAC_BITS divider stages. Throughput: one matrix
//   per cycle while neither queue is full; the pipelines take one bit per
//   stage. Reset (synchronous, active low) empties both queues and the pipe.
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a Q2.14 rotation matrix to a saturated Q2.14 unit quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [DATA_WIDTH-1:0] i_m00,
    input  wire logic signed [DATA_WIDTH-1:0] i_m01,
    input  wire logic signed [DATA_WIDTH-1:0] i_m02,
    input  wire logic signed [DATA_WIDTH-1:0] i_m10,
    input  wire logic signed [DATA_WIDTH-1:0] i_m11,
    input  wire logic signed [DATA_WIDTH-1:0] i_m12,
    input  wire logic signed [DATA_WIDTH-1:0] i_m20,
    input  wire logic signed [DATA_WIDTH-1:0] i_m21,
    input  wire logic signed [DATA_WIDTH-1:0] i_m22,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [DATA_WIDTH-1:0]      o_qw,
    output logic signed [DATA_WIDTH-1:0]      o_qx,
    output logic signed [DATA_WIDTH-1:0]      o_qy,
    output logic signed [DATA_WIDTH-1:0]      o_qz
);
    import rmq_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SU = ((W + 2) > (F + 2)) ? (W + 2) : (F + 2);
    localparam int EW = 2 + SU + 3 + 3 * (W + 1);

    t_slot           f_slot;
    logic [SU-1:0]   f_rad;
    logic [2:0]      f_neg;
    logic [2:0][W:0] f_mag;
    logic [EW-1:0]   mid_data;
    logic            mid_empty, take;

    rmq_front #(.W(W), .F(F), .SU(SU)) u_front (
        .i_m00  (i_m00), .i_m01 (i_m01), .i_m02 (i_m02),
        .i_m10  (i_m10), .i_m11 (i_m11), .i_m12 (i_m12),
        .i_m20  (i_m20), .i_m21 (i_m21), .i_m22 (i_m22),
        .o_slot (f_slot),
        .o_rad  (f_rad),
        .o_neg  (f_neg),
        .o_mag  (f_mag)
    );

    rmq_fifo #(.WIDTH(EW), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_slot, f_rad, f_neg, f_mag}),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    rmq_back #(.W(W), .F(F), .SU(SU)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!mid_empty),
        .o_take  (take),
        .i_slot  (t_slot'(mid_data[EW-1 -: 2])),
        .i_rad   (mid_data[EW-3 -: SU]),
        .i_neg   (mid_data[3*(W+1) +: 3]),
        .i_mag   (mid_data[3*(W+1)-1:0]),
        .i_pop   (pop),
        .o_empty (empty),
        .o_qw    (o_qw),
        .o_qx    (o_qx),
        .o_qy    (o_qy),
        .o_qz    (o_qz)
    );

endmodule
`default_nettype wire

// ----- verif/rotation_matrix_to_quaternion_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// Pushes matrices through the converter and compares each quaternion popped
// from the result queue with an in-bench fixed-point prediction.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam longint SMAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam longint ONE = 64'sd1 <<< FB;

    typedef logic signed [DW-1:0] t_fix;
    typedef struct packed {
        t_fix w;
        t_fix x;
        t_fix y;
        t_fix z;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_fix mat [9];
    logic full, empty;
    t_fix o_qw, o_qx, o_qy, o_qz;

    t_quat quat_queue[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit failed = 1'b0;

    initial for (int n = 0; n < 9; n++) mat[n] = '0;

    rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_m00(mat[0]), .i_m01(mat[1]), .i_m02(mat[2]),
        .i_m10(mat[3]), .i_m11(mat[4]), .i_m12(mat[5]),
        .i_m20(mat[6]), .i_m21(mat[7]), .i_m22(mat[8]),
        .empty(empty), .pop(pop),
        .o_qw(o_qw), .o_qx(o_qx), .o_qy(o_qy), .o_qz(o_qz)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint fix_sqrt(longint s);
        longint unsigned n, res, b;
        if (s <= 0) return 0;
        n = longint'(s) << FB;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint half_over_root(longint d, longint root);
        longint unsigned mag, q;
        if (root == 0) return (d > 0) ? SMAX : (d < 0) ? SMIN : 0;
        mag = (d < 0) ? -d : d;
        q = (mag << FB) / (2 * root);
        if (d < 0) return (q > SMAX + 1) ? SMIN : -longint'(q);
        return (q > SMAX) ? SMAX : longint'(q);
    endfunction

    function automatic longint clip(longint v);
        return (v > SMAX) ? SMAX : (v < SMIN) ? SMIN : v;
    endfunction

    function automatic t_quat predict_quat(t_fix a [9]);
        longint m [3][3];
        longint q [4];
        longint tr, root;
        int i, j, k;
        t_quat r;
        for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'(a[n]);
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            root = fix_sqrt(tr + ONE);
            q[0] = clip(root >>> 1);
            q[1] = half_over_root(m[2][1] - m[1][2], root);
            q[2] = half_over_root(m[0][2] - m[2][0], root);
            q[3] = half_over_root(m[1][0] - m[0][1], root);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            root = fix_sqrt(m[i][i] - m[j][j] - m[k][k] + ONE);
            q[1 + i] = clip(root >>> 1);
            q[0] = half_over_root(m[k][j] - m[j][k], root);
            q[1 + j] = half_over_root(m[j][i] + m[i][j], root);
            q[1 + k] = half_over_root(m[k][i] + m[i][k], root);
        end
        r.w = t_fix'(q[0]);
        r.x = t_fix'(q[1]);
        r.y = t_fix'(q[2]);
        r.z = t_fix'(q[3]);
        return r;
    endfunction

    task automatic push_matrix(t_fix a [9]);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        for (int n = 0; n < 9; n++) mat[n] <= a[n];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        quat_queue.push_back(predict_quat(a));
    endtask

    task automatic check_field(string name, t_fix exp_v, t_fix act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected quaternion %0d %0d %0d %0d",
                         $time, o_qw, o_qx, o_qy, o_qz);
                failed = 1'b1;
            end else begin
                t_quat e;
                e = quat_queue.pop_front();
                check_field("qw", e.w, o_qw);
                check_field("qx", e.x, o_qx);
                check_field("qy", e.y, o_qy);
                check_field("qz", e.z, o_qz);
            end
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_fix rand_fix();
        case ($urandom_range(5))
            0: return t_fix'(SMAX);
            1: return t_fix'(SMIN);
            2: return t_fix'($urandom_range(2 * ONE) - ONE);
            default: return t_fix'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        t_fix a [9];
        for (int c = 0; c < 20; c++) begin
            for (int n = 0; n < 9; n++) a[n] = '0;
            case (c)
                0: begin a[0] = t_fix'(ONE); a[4] = t_fix'(ONE); a[8] = t_fix'(ONE); end
                1: begin a[0] = t_fix'(ONE); a[4] = t_fix'(-ONE); a[8] = t_fix'(-ONE); end
                2: begin a[0] = t_fix'(-ONE); a[4] = t_fix'(ONE); a[8] = t_fix'(-ONE); end
                3: begin a[0] = t_fix'(-ONE); a[4] = t_fix'(-ONE); a[8] = t_fix'(ONE); end
                4: ;
                5: for (int n = 0; n < 9; n++) a[n] = t_fix'(SMAX);
                6: for (int n = 0; n < 9; n++) a[n] = t_fix'(SMIN);
                7: begin a[0] = t_fix'(SMIN); a[4] = t_fix'(SMIN); a[8] = t_fix'(SMIN);
                          a[1] = t_fix'(5); a[3] = t_fix'(-7); a[5] = t_fix'(3);
                          a[7] = t_fix'(-3); end
                8: begin a[0] = t_fix'(-ONE); a[4] = t_fix'(-ONE); a[8] = t_fix'(-ONE); end
                9: begin a[0] = t_fix'(ONE); a[4] = t_fix'(ONE); a[8] = t_fix'(-ONE); end
                10: begin a[0] = t_fix'(-ONE); a[4] = t_fix'(ONE); a[8] = t_fix'(ONE); end
                11: begin a[0] = '0; a[4] = t_fix'(-ONE); a[8] = t_fix'(ONE);
                           a[1] = t_fix'(ONE); a[3] = t_fix'(ONE); end
                12: begin a[0] = t_fix'(ONE); a[4] = t_fix'(-ONE); a[8] = t_fix'(-ONE);
                           a[1] = t_fix'(SMAX); a[3] = t_fix'(SMAX); a[2] = t_fix'(SMIN);
                           a[6] = t_fix'(SMIN); end
                13: begin a[0] = t_fix'(SMAX); a[4] = t_fix'(SMAX); a[8] = t_fix'(SMAX);
                           a[7] = t_fix'(SMAX); a[5] = t_fix'(SMIN); end
                14: begin a[0] = t_fix'(1); a[4] = '0; a[8] = '0; a[2] = t_fix'(SMIN); end
                15: begin a[0] = '0; a[4] = '0; a[8] = '0; a[1] = t_fix'(-1);
                           a[3] = t_fix'(1); end
                default: for (int n = 0; n < 9; n++) a[n] = rand_fix();
            endcase
            push_matrix(a);
        end
    endtask

    task automatic test_random(int count);
        t_fix a [9];
        int ax;
        for (int c = 0; c < count; c++) begin
            if ($urandom_range(3) != 0) begin
                // near-rotation: signed permutation with small noise
                for (int n = 0; n < 9; n++) a[n] = t_fix'($urandom_range(2000) - 1000);
                ax = $urandom_range(2);
                for (int r = 0; r < 3; r++)
                    a[r * 3 + (r + ax) % 3] = $urandom_range(1) ? t_fix'(ONE - $urandom_range(3000))
                                                              : t_fix'(-ONE + $urandom_range(3000));
            end else begin
                for (int n = 0; n < 9; n++) a[n] = rand_fix();
            end
            push_matrix(a);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(130);
        send_idle_pct = 82;
        test_random(120);
        send_idle_pct = 0;
        recv_stall_pct = 82;
        test_random(120);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        test_random(120);
        drain();
        if (!failed)
            $display("** rotation_matrix_to_quaternion_unit: PASSED **");
        else
            $display("** rotation_matrix_to_quaternion_unit: FAILED **");
        $finish;
    end

    initial begin
        #2ms;
        $display("** rotation_matrix_to_quaternion_unit: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/rmq_pkg.sv
rtl/rmq_fifo.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion_unit.sv
verif/rotation_matrix_to_quaternion_unit_tb.sv
